[rtl/jhpe_pkg.sv]
// Shared types and constants for the JPEG Huffman pair encoder.
package jhpe_pkg;

    // Fixed field widths of the beats
    localparam int CODE_IN_W  = 16;
    localparam int LEN_W      = 5;
    localparam int SYM_W      = 8;
    localparam int RUN_W      = 4;
    localparam int AMP_W      = 12;
    localparam int CLS_W      = 4;
    localparam int PACK_W     = 27;
    localparam int COUNT_W    = 5;
    localparam int TABLE_DEPTH = 256;

    typedef enum logic [1:0] {
        ACT_LOAD_DC = 2'd0,
        ACT_LOAD_AC = 2'd1,
        ACT_ENC_DC  = 2'd2,
        ACT_ENC_AC  = 2'd3
    } t_action;

    typedef struct packed {
        t_action                 action;
        logic [SYM_W-1:0]        symbol;
        logic [CODE_IN_W-1:0]    code_bits;
        logic [LEN_W-1:0]        code_length;
        logic [RUN_W-1:0]        run_zeros;
        logic signed [AMP_W-1:0] amplitude;
    } t_in_beat;

    typedef struct packed {
        logic [PACK_W-1:0]  packed_bits;
        logic [COUNT_W-1:0] bit_count;
        logic               missing_code;
    } t_out_beat;

    // Classified pair: table symbol, amplitude class and amplitude bits
    typedef struct packed {
        logic [SYM_W-1:0] sym;
        logic [CLS_W-1:0] cls;
        logic [AMP_W-1:0] amp_bits;
    } t_pair_info;

endpackage

[rtl/jhpe_classify.sv]
// Amplitude saturation, class priority encode and symbol formation.
module jhpe_classify import jhpe_pkg::*; #(
    parameter int AMP_BITS = 11
) (
    input  t_action                 i_action,
    input  logic [RUN_W-1:0]        i_run_zeros,
    input  logic signed [AMP_W-1:0] i_amplitude,
    output t_pair_info              o_info
);

    localparam int XW = 17;
    localparam logic signed [XW-1:0] LIM = XW'((1 << AMP_BITS) - 1);

    logic signed [XW-1:0] amp_x;
    logic signed [XW-1:0] sat;
    logic signed [XW-1:0] mag_x;
    logic signed [XW-1:0] amp_m1;
    logic [AMP_W-1:0]     mag;
    logic [CLS_W-1:0]     cls;
    logic [AMP_W-1:0]     mask;
    logic [RUN_W-1:0]     run_eff;

    // Clamp the amplitude to the coded range
    always_comb begin
        amp_x = XW'(i_amplitude);
        if (amp_x > LIM) begin
            sat = LIM;
        end else if (amp_x < -LIM) begin
            sat = -LIM;
        end else begin
            sat = amp_x;
        end
        mag_x  = (sat < 0) ? -sat : sat;
        mag    = mag_x[AMP_W-1:0];
        amp_m1 = (sat < 0) ? sat - XW'(1) : sat;
    end

    // Find the bit length of the magnitude
    always_comb begin
        cls = '0;
        for (int i = 0; i < AMP_W; i++) begin
            if (mag[i]) begin
                cls = CLS_W'(i + 1);
            end
        end
    end

    // Keep the class low bits and build the table symbol
    always_comb begin
        mask            = ~({AMP_W{1'b1}} << cls);
        run_eff         = (i_action == ACT_ENC_DC) ? '0 : i_run_zeros;
        o_info.cls      = cls;
        o_info.amp_bits = amp_m1[AMP_W-1:0] & mask;
        o_info.sym      = {run_eff, cls};
    end

endmodule

[rtl/jhpe_code_table.sv]
// One 256-entry code table with per-entry valid bits and a registered read.
module jhpe_code_table import jhpe_pkg::*; #(
    parameter int MAX_CODE_LEN = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr_en,
    input  logic [SYM_W-1:0]     i_wr_addr,
    input  logic [CODE_IN_W-1:0] i_wr_bits,
    input  logic [LEN_W-1:0]     i_wr_len,
    input  logic                 i_rd_en,
    input  logic [SYM_W-1:0]     i_rd_addr,
    output logic [((MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W)-1:0] o_rd_code,
    output logic [LEN_W-1:0]     o_rd_len
);

    localparam int CODE_W  = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
    localparam int ENTRY_W = CODE_W + LEN_W;
    localparam int MW      = 32;

    logic [ENTRY_W-1:0] r_mem [TABLE_DEPTH];
    logic               r_vld [TABLE_DEPTH];
    logic [ENTRY_W-1:0] r_rd_entry;
    logic               r_rd_vld;
    logic [LEN_W-1:0]   wr_len;
    logic [MW-1:0]      wr_mask;
    logic [MW-1:0]      wr_code;

    // Drop overlong lengths and stray bits above the length
    always_comb begin
        wr_len  = (i_wr_len > LEN_W'(MAX_CODE_LEN)) ? '0 : i_wr_len;
        wr_mask = ~({MW{1'b1}} << wr_len);
        wr_code = MW'(i_wr_bits) & wr_mask;
    end

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= {wr_code[CODE_W-1:0], wr_len};
        end
    end

    // Mark written entries; reset makes every entry read as absent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // Read the entry
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_entry <= r_mem[i_rd_addr];
            r_rd_vld   <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_code = r_rd_entry[ENTRY_W-1:LEN_W];
    assign o_rd_len  = r_rd_vld ? r_rd_entry[LEN_W-1:0] : '0;

endmodule

[rtl/jhpe_pack.sv]
// Joins codeword and amplitude bits into one result beat.
module jhpe_pack import jhpe_pkg::*; #(
    parameter int CODE_W = 16
) (
    input  logic [CODE_W-1:0] i_code,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [CLS_W-1:0]  i_cls,
    input  logic [AMP_W-1:0]  i_amp_bits,
    output t_out_beat         o_beat
);

    localparam int SW = 32;

    logic [SW-1:0]      joined;
    logic [LEN_W:0]     total;

    // Shift the codeword up by the class and append the amplitude bits
    always_comb begin
        joined = (SW'(i_code) << i_cls) | SW'(i_amp_bits);
        total  = (LEN_W+1)'(i_len) + (LEN_W+1)'(i_cls);
        if (i_len == '0) begin
            o_beat.packed_bits  = '0;
            o_beat.bit_count    = '0;
            o_beat.missing_code = 1'b1;
        end else begin
            o_beat.packed_bits  = joined[PACK_W-1:0];
            o_beat.bit_count    = total[COUNT_W-1:0];
            o_beat.missing_code = 1'b0;
        end
    end

endmodule

[rtl/jpeg_huffman_pair_encoder_unit.sv]
// JPEG Huffman pair encoder: table loads and (run, amplitude) pair coding.
// An encode beat passes the registered table read with the lookup stage, then the output register.
// Throughput: one beat per cycle while the output is not stalled; set by the registered table read followed
// by the output register. Load beats write a table and give no result.
// Reset (synchronous, active low) empties both pipeline stages and marks
// every table entry absent at once; no clearing pass is needed.
module jpeg_huffman_pair_encoder_unit import jhpe_pkg::*; #(
    parameter int MAX_CODE_LEN = 16,
    parameter int AMP_BITS     = 11
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    localparam int CODE_W = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;

    t_pair_info        pair;
    logic              out_free;
    logic              s1_adv;
    logic              in_acc;
    logic              is_enc;
    logic              is_ac;
    logic              n_s1_valid;
    logic              r_s1_valid;
    logic              r_s1_ac;
    t_pair_info        r_s1_info;
    logic              r_out_valid;
    t_out_beat         r_out;
    t_out_beat         n_out;
    logic [CODE_W-1:0] dc_code;
    logic [CODE_W-1:0] ac_code;
    logic [LEN_W-1:0]  dc_len;
    logic [LEN_W-1:0]  ac_len;

    // Advance a stage when the one after it is free or draining
    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_free;
    assign o_in_stall = !s1_adv;
    assign in_acc     = i_in_valid && s1_adv;
    assign is_enc     = (i_in_data.action == ACT_ENC_DC) || (i_in_data.action == ACT_ENC_AC);
    assign is_ac      = (i_in_data.action == ACT_LOAD_AC) || (i_in_data.action == ACT_ENC_AC);
    assign n_s1_valid = in_acc && is_enc;

    jhpe_classify #(
        .AMP_BITS (AMP_BITS)
    ) u_classify (
        .i_action    (i_in_data.action),
        .i_run_zeros (i_in_data.run_zeros),
        .i_amplitude (i_in_data.amplitude),
        .o_info      (pair)
    );

    jhpe_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_dc_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && !is_enc && !is_ac),
        .i_wr_addr (i_in_data.symbol),
        .i_wr_bits (i_in_data.code_bits),
        .i_wr_len  (i_in_data.code_length),
        .i_rd_en   (n_s1_valid && !is_ac),
        .i_rd_addr (pair.sym),
        .o_rd_code (dc_code),
        .o_rd_len  (dc_len)
    );

    jhpe_code_table #(
        .MAX_CODE_LEN (MAX_CODE_LEN)
    ) u_ac_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (in_acc && !is_enc && is_ac),
        .i_wr_addr (i_in_data.symbol),
        .i_wr_bits (i_in_data.code_bits),
        .i_wr_len  (i_in_data.code_length),
        .i_rd_en   (n_s1_valid && is_ac),
        .i_rd_addr (pair.sym),
        .o_rd_code (ac_code),
        .o_rd_len  (ac_len)
    );

    // Lookup stage: hold the classified pair alongside the table read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_s1_valid) begin
            r_s1_info <= pair;
            r_s1_ac   <= is_ac;
        end
    end

    jhpe_pack #(
        .CODE_W (CODE_W)
    ) u_pack (
        .i_code     (r_s1_ac ? ac_code : dc_code),
        .i_len      (r_s1_ac ? ac_len : dc_len),
        .i_cls      (r_s1_info.cls),
        .i_amp_bits (r_s1_info.amp_bits),
        .o_beat     (n_out)
    );

    // Output register: load when free, hold while stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[rtl/jhpe_checker.sv]
// Port-level assertions for the JPEG Huffman pair encoder, bound to the top.
module jhpe_checker import jhpe_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_beat  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_beat o_out_data
);

    // A result stalled by the sink stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result beat dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A missing code carries no bits
    a_missing_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.missing_code |->
            (o_out_data.bit_count == '0) && (o_out_data.packed_bits == '0))
        else $error("missing code with nonzero bits");

    // Reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // A new result only follows an accepted encode beat that passed the lookup stage and the output register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |->
            $past(i_in_valid && !o_in_stall &&
                  ((i_in_data.action == ACT_ENC_DC) || (i_in_data.action == ACT_ENC_AC)), 2))
        else $error("result without an encode beat");

endmodule

bind jpeg_huffman_pair_encoder_unit jhpe_checker u_jhpe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

[tb/pair_code_checker.sv]
// Checker for the JPEG Huffman pair encoder: predicts each coded pair and compares beats.
module pair_code_checker import jhpe_pkg::*; #(
    parameter int MAX_CODE_LEN = 16,
    parameter int AMP_BITS     = 11
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_beat i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    localparam int RUN_SHIFT = 4;

    // Mirrored code tables, index 0 for DC and 1 for AC
    logic [CODE_IN_W-1:0] code_word [2][TABLE_DEPTH];
    logic [LEN_W-1:0]     code_len  [2][TABLE_DEPTH];

    t_out_beat coded_pairs_q[$];
    int        fails = 0;

    function automatic int table_of(input t_action act);
        return (act == ACT_LOAD_AC || act == ACT_ENC_AC) ? 1 : 0;
    endfunction

    // Write one table entry; overlong lengths mark the symbol absent
    function automatic void store_entry(input t_in_beat b);
        int len;
        int tsel;
        len  = b.code_length;
        tsel = table_of(b.action);
        if (len > MAX_CODE_LEN) len = 0;
        code_len[tsel][b.symbol]  = len[LEN_W-1:0];
        code_word[tsel][b.symbol] = CODE_IN_W'(b.code_bits & ((32'd1 << len) - 1));
    endfunction

    // Classify the amplitude, look up the codeword and append the amplitude bits
    function automatic t_out_beat code_pair(input t_in_beat b);
        int               amp;
        int               lim;
        int               mag;
        int               cls;
        int               run;
        int               sym;
        int               tsel;
        int               amp_bits;
        logic [LEN_W-1:0] clen;
        logic [63:0]      packed_val;
        t_out_beat        r;
        amp  = {{(32-AMP_W){b.amplitude[AMP_W-1]}}, b.amplitude};
        lim  = (1 << AMP_BITS) - 1;
        if (amp > lim) amp = lim;
        if (amp < -lim) amp = -lim;
        mag  = (amp < 0) ? -amp : amp;
        for (cls = 0; (mag >> cls) != 0; cls++) ;
        run  = (b.action == ACT_ENC_DC) ? 0 : int'(b.run_zeros);
        sym  = ((run << RUN_SHIFT) | cls) & 8'hFF;
        tsel = table_of(b.action);
        clen = code_len[tsel][sym];
        r    = '0;
        if (clen == 0) begin
            r.missing_code = 1'b1;
        end else begin
            amp_bits        = ((amp < 0) ? amp - 1 : amp) & ((1 << cls) - 1);
            packed_val      = (64'(code_word[tsel][sym]) << cls) | 64'(amp_bits);
            r.packed_bits   = packed_val[PACK_W-1:0];
            r.bit_count     = COUNT_W'(int'(clen) + cls);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat got;
        if (!i_rst_n) begin
            // Clear the mirrored tables and drop all expectations
            for (int t = 0; t < 2; t++) begin
                for (int e = 0; e < TABLE_DEPTH; e++) begin
                    code_word[t][e] = '0;
                    code_len[t][e]  = '0;
                end
            end
            coded_pairs_q.delete();
            o_pending    <= 0;
            o_fail_count <= 0;
        end else begin
            // Apply a load or queue the coded pair of an encode
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.action == ACT_LOAD_DC || i_in_data.action == ACT_LOAD_AC) begin
                    store_entry(i_in_data);
                end else begin
                    coded_pairs_q.insert(coded_pairs_q.size(), code_pair(i_in_data));
                end
            end
            // Compare the result beat with the oldest coded pair
            if (i_out_valid && !i_out_stall) begin
                got = i_out_data;
                if (coded_pairs_q.size() == 0) begin
                    $error("unexpected result beat: packed_bits %h bit_count %0d missing_code %b",
                           got.packed_bits, got.bit_count, got.missing_code);
                    fails++;
                end else begin
                    want = coded_pairs_q.pop_front();
                    if (got.packed_bits !== want.packed_bits) begin
                        $error("packed_bits: expected %h, actual %h",
                               want.packed_bits, got.packed_bits);
                        fails++;
                    end
                    if (got.bit_count !== want.bit_count) begin
                        $error("bit_count: expected %0d, actual %0d",
                               want.bit_count, got.bit_count);
                        fails++;
                    end
                    if (got.missing_code !== want.missing_code) begin
                        $error("missing_code: expected %b, actual %b",
                               want.missing_code, got.missing_code);
                        fails++;
                    end
                end
            end
            o_pending    <= coded_pairs_q.size();
            o_fail_count <= fails;
        end
    end

endmodule

[tb/testbench.sv]
// Top of the JPEG Huffman pair encoder testbench: clock, reset, stimulus and verdict.
module testbench;
    import jhpe_pkg::*;

    localparam int MAX_CODE_LEN = 16;
    localparam int AMP_BITS     = 11;
    localparam int LONG_HOLD    = 300;
    localparam int PHASE_ITEMS  = 225;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_beat  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_beat out_data;
    int        fail_count;
    int        pending;

    int        send_idle_pct = 0;
    int        stall_pct     = 0;
    bit        hold_request  = 1'b0;

    jpeg_huffman_pair_encoder_unit #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .AMP_BITS    (AMP_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    pair_code_checker #(
        .MAX_CODE_LEN(MAX_CODE_LEN),
        .AMP_BITS    (AMP_BITS)
    ) checker_inst (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #5 clk = ~clk;

    // Drive the result stall; a requested long hold is counted here
    initial begin
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    // Random content in every field; callers overwrite the ones that matter
    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b.action      = t_action'($urandom_range(3));
        b.symbol      = SYM_W'($urandom_range(255));
        b.code_bits   = CODE_IN_W'($urandom_range(16'hFFFF));
        b.code_length = LEN_W'($urandom_range(31));
        b.run_zeros   = RUN_W'($urandom_range(15));
        b.amplitude   = AMP_W'($urandom_range(12'hFFF));
        return b;
    endfunction

    function automatic t_in_beat load_beat(input t_action act, input int sym,
                                           input int bits, input int len);
        t_in_beat b;
        b             = noise_beat();
        b.action      = act;
        b.symbol      = sym[SYM_W-1:0];
        b.code_bits   = bits[CODE_IN_W-1:0];
        b.code_length = len[LEN_W-1:0];
        return b;
    endfunction

    function automatic t_in_beat pair_beat(input t_action act, input int run, input int amp);
        t_in_beat b;
        b           = noise_beat();
        b.action    = act;
        b.run_zeros = run[RUN_W-1:0];
        b.amplitude = amp[AMP_W-1:0];
        return b;
    endfunction

    // Amplitude of a random class, occasionally any 12-bit value
    function automatic int random_amplitude();
        int cls;
        int mag;
        if ($urandom_range(9) == 0) return $urandom_range(4095) - 2048;
        cls = $urandom_range(11);
        if (cls == 0) return 0;
        mag = (1 << (cls - 1)) + $urandom_range((1 << (cls - 1)) - 1);
        return $urandom_range(1) ? -mag : mag;
    endfunction

    // Mostly encodes of well-shaped pairs, some loads that reshape the tables
    function automatic t_in_beat random_beat();
        int len;
        int sym;
        if ($urandom_range(99) < 15) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(1, 16);
            if ($urandom_range(1)) begin
                sym = ($urandom_range(2) == 0) ? $urandom_range(255) : $urandom_range(11);
                return load_beat(ACT_LOAD_DC, sym, $urandom_range(16'hFFFF), len);
            end
            sym = ($urandom_range(2) == 0) ? $urandom_range(255)
                                           : ($urandom_range(15) << 4) | $urandom_range(10);
            return load_beat(ACT_LOAD_AC, sym, $urandom_range(16'hFFFF), len);
        end
        if ($urandom_range(99) < 30) return pair_beat(ACT_ENC_DC, 0, random_amplitude());
        return pair_beat(ACT_ENC_AC, $urandom_range(15), random_amplitude());
    endfunction

    // Offer one beat, with random idle cycles first, and hold it until taken
    task automatic send_beat(input t_in_beat b);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Stop offering and wait until every coded pair has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    initial begin
        int phase;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: table extremes, absent symbols, saturation and ignored DC run
        send_beat(load_beat(ACT_LOAD_DC, 8'h00, 16'hFFFF, 2));
        send_beat(load_beat(ACT_LOAD_DC, 8'h0B, 16'hFFFF, 16));
        send_beat(load_beat(ACT_LOAD_DC, 8'h01, 16'h0000, 17));
        send_beat(load_beat(ACT_LOAD_DC, 8'h02, 16'h0005, 31));
        send_beat(load_beat(ACT_LOAD_DC, 8'h05, 16'h0003, 3));
        send_beat(load_beat(ACT_LOAD_AC, 8'h00, 16'hFFFF, 4));
        send_beat(load_beat(ACT_LOAD_AC, 8'hF0, 16'h07F9, 11));
        send_beat(load_beat(ACT_LOAD_AC, 8'hFB, 16'hFFFE, 16));
        send_beat(load_beat(ACT_LOAD_AC, 8'h11, 16'h0000, 1));
        send_beat(pair_beat(ACT_ENC_DC, 0, 0));
        send_beat(pair_beat(ACT_ENC_DC, 15, -2048));
        send_beat(pair_beat(ACT_ENC_DC, 0, 2047));
        send_beat(pair_beat(ACT_ENC_DC, 7, -1));
        send_beat(pair_beat(ACT_ENC_DC, 0, 2));
        send_beat(pair_beat(ACT_ENC_DC, 0, -17));
        send_beat(pair_beat(ACT_ENC_AC, 0, 0));
        send_beat(pair_beat(ACT_ENC_AC, 15, 0));
        send_beat(pair_beat(ACT_ENC_AC, 15, -2048));
        send_beat(pair_beat(ACT_ENC_AC, 15, 1024));
        send_beat(pair_beat(ACT_ENC_AC, 1, -1));
        send_beat(pair_beat(ACT_ENC_AC, 3, 5));
        send_beat(load_beat(ACT_LOAD_AC, 8'h11, 16'h0001, 0));
        send_beat(pair_beat(ACT_ENC_AC, 1, 1));
        drain();

        // Fill both tables with the symbols that real coefficient streams use
        for (int c = 0; c < 12; c++) begin
            send_beat(load_beat(ACT_LOAD_DC, c, $urandom_range(16'hFFFF), $urandom_range(1, 16)));
        end
        send_beat(load_beat(ACT_LOAD_AC, 8'h00, $urandom_range(16'hFFFF), $urandom_range(1, 16)));
        send_beat(load_beat(ACT_LOAD_AC, 8'hF0, $urandom_range(16'hFFFF), $urandom_range(1, 16)));
        for (int r = 0; r < 16; r++) begin
            for (int c = 1; c < 11; c++) begin
                send_beat(load_beat(ACT_LOAD_AC, (r << 4) | c, $urandom_range(16'hFFFF),
                                    $urandom_range(1, 16)));
            end
        end

        // Random pairs under each idling pattern, draining between patterns
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 60; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 60; end
                default: begin send_idle_pct = 29; stall_pct = 29; end
            endcase
            repeat (PHASE_ITEMS) send_beat(random_beat());
            drain();
        end

        // Back up the pipeline behind a long result hold while beats keep coming
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_request  = 1'b1;
        repeat (60) send_beat(random_beat());
        send_idle_pct = 29;
        stall_pct     = 29;
        repeat (150) send_beat(random_beat());
        drain();

        repeat (10) @(posedge clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

[sim.f]
rtl/jhpe_pkg.sv
rtl/jhpe_classify.sv
rtl/jhpe_code_table.sv
rtl/jhpe_pack.sv
rtl/jpeg_huffman_pair_encoder_unit.sv
rtl/jhpe_checker.sv
tb/pair_code_checker.sv
tb/testbench.sv
